>>> hdl/rpc_pkg.sv
// Shared types, constants and functions for the RGBE pixel codec.
`timescale 1ns / 1ps
`default_nettype none
package rpc_pkg;

  typedef enum logic {
    REQ_DECODE = 1'b0,
    REQ_ENCODE = 1'b1
  } req_t;

  // The significand of 255.999 in single precision, hidden bit included.
  localparam logic [23:0] SCALE_MANT = 24'hFFFFBE;
  // 1e-32 in single precision.
  localparam logic [31:0] TINY_BITS = 32'h0A4FB11F;
  localparam logic [7:0] EXP_MAX = 8'hFF;
  localparam logic [7:0] EXP_OVERFLOW = 8'd254;
  localparam logic [7:0] EXP_OFFSET = 8'd2;
  localparam logic [8:0] SHIFT_BIAS = 9'd15;
  localparam logic [8:0] SHIFT_LIMIT = 9'd48;

  typedef struct packed {
    logic       enc;
    logic       sat;
    logic       zero;
    logic [7:0] ed;
  } rpc_ctl_t;

  // Maps a float bit pattern to a key whose unsigned order follows the float order.
  function automatic logic [31:0] order_key(input logic [31:0] f);
    order_key = f[31] ? ~f : {1'b1, f[30:0]};
  endfunction

  // Builds the exact single for (byte + 0.5) / 256 * 2^(ex - 128).
  function automatic logic [31:0] decode_channel(input logic [7:0] b, input logic [7:0] ex);
    logic [8:0]  m;
    logic [3:0]  p;
    logic [9:0]  be;
    logic [31:0] mw;
    m = {b, 1'b1};
    p = 4'd0;
    for (int i = 1; i < 9; i++) begin
      if (m[i]) p = 4'(i);
    end
    be = 10'(p) + 10'(ex) - 10'd10;
    mw = 32'(m);
    if (!be[9] && be != 10'd0) begin
      decode_channel = {1'b0, be[7:0], 23'((mw << (5'd23 - 5'(p))))};
    end else begin
      decode_channel = mw << (6'(ex) + 6'd12);
    end
  endfunction

endpackage
`default_nettype wire

>>> hdl/rpc_front.sv
// Shared exponent and special case detection across the three colour lanes.
`timescale 1ns / 1ps
`default_nettype none
module rpc_front
  import rpc_pkg::*;
(
  input  wire logic        enc,
  input  wire logic [31:0] red_f,
  input  wire logic [31:0] green_f,
  input  wire logic [31:0] blue_f,
  input  wire logic [7:0]  red_b,
  input  wire logic [7:0]  green_b,
  input  wire logic [7:0]  blue_b,
  input  wire logic [7:0]  exp_b,
  output rpc_ctl_t         ctl
);

  logic [31:0] d_gb;
  logic [31:0] d;
  logic        nonfinite;
  logic        big;

  always_comb begin
    d_gb = (order_key(green_f) > order_key(blue_f)) ? green_f : blue_f;
    d = (order_key(red_f) > order_key(d_gb)) ? red_f : d_gb;
    nonfinite = (red_f[30:23] == EXP_MAX) || (green_f[30:23] == EXP_MAX) ||
                (blue_f[30:23] == EXP_MAX);
    big = !d[31] && (d > TINY_BITS);
    ctl.enc = enc;
    ctl.ed = d[30:23];
    if (enc) begin
      ctl.sat = nonfinite || (big && d[30:23] == EXP_OVERFLOW);
      ctl.zero = !nonfinite && !big;
    end else begin
      ctl.sat = 1'b0;
      ctl.zero = (red_b == 8'd0) && (green_b == 8'd0) && (blue_b == 8'd0) && (exp_b == 8'd0);
    end
  end

endmodule
`default_nettype wire

>>> hdl/rpc_lane.sv
// One colour lane: scaled mantissa product, rounding and decode.
`timescale 1ns / 1ps
`default_nettype none
module rpc_lane
  import rpc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] fl,
  input  wire logic [7:0]  byte_in,
  input  wire logic [7:0]  ex,
  input  wire logic [7:0]  ed,
  output logic [7:0]       byte_out,
  output logic [31:0]      float_out
);

  logic [47:0] prod_r, prod_nxt;
  logic [8:0]  sh_r, sh_nxt;
  logic        pos_r, pos_nxt;
  logic [31:0] dec_r, dec_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic [31:0] flo_r;
  logic [23:0] mc;
  logic [7:0]  ecp;
  logic [47:0] shifted;
  logic [32:0] x;
  logic [7:0]  ip;
  logic [24:0] fr;
  logic [25:0] thresh;
  logic        up;

  always_comb begin
    mc = (fl[30:23] == 8'd0) ? {1'b0, fl[22:0]} : {1'b1, fl[22:0]};
    ecp = (fl[30:23] == 8'd0) ? 8'd1 : fl[30:23];
    prod_nxt = 48'(mc) * 48'(SCALE_MANT);
    sh_nxt = 9'(ed) + SHIFT_BIAS - 9'(ecp);
    pos_nxt = !fl[31] && (fl[30:0] != 31'd0);
    dec_nxt = decode_channel(byte_in, ex);
  end

  always_comb begin
    shifted = (sh_r >= SHIFT_LIMIT) ? 48'd0 : (prod_r >> sh_r);
    x = shifted[32:0];
    ip = x[32:25];
    fr = x[24:0];
    thresh = 26'h1FFFFFF;
    for (int i = 0; i < 8; i++) begin
      if (ip[i]) thresh = 26'h2000000 - (26'd1 << (i + 1));
    end
    up = 26'(fr) >= thresh;
    if (!pos_r) begin
      byte_nxt = 8'd0;
    end else if (ip == 8'hFF || !up) begin
      byte_nxt = ip;
    end else begin
      byte_nxt = ip + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      sh_r <= sh_nxt;
      pos_r <= pos_nxt;
      dec_r <= dec_nxt;
      byte_r <= byte_nxt;
      flo_r <= dec_r;
    end
  end

  assign byte_out = byte_r;
  assign float_out = flo_r;

endmodule
`default_nettype wire

>>> hdl/rgbe_pixel_codec.sv
// Top level of the RGBE pixel codec.
// Throughput is one word per cycle; the three stages advance together and stall
// together when the result is not taken.
// Reset, synchronous and active low, clears the stage valid flags only.
`timescale 1ns / 1ps
`default_nettype none
module rgbe_pixel_codec
  import rpc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_req_type,
  input  wire logic [31:0] in_red_float_in,
  input  wire logic [31:0] in_green_float_in,
  input  wire logic [31:0] in_blue_float_in,
  input  wire logic [7:0]  in_red_byte_in,
  input  wire logic [7:0]  in_green_byte_in,
  input  wire logic [7:0]  in_blue_byte_in,
  input  wire logic [7:0]  in_shared_exp_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_red_float_out,
  output logic [31:0]      out_green_float_out,
  output logic [31:0]      out_blue_float_out,
  output logic [7:0]       out_red_byte_out,
  output logic [7:0]       out_green_byte_out,
  output logic [7:0]       out_blue_byte_out,
  output logic [7:0]       out_shared_exp_out
);

  logic        en;
  logic [2:0]  v_r, v_nxt;
  rpc_ctl_t    ctl_nxt, ctl1_r, ctl2_r, ctl3_r;
  logic [31:0] rf_r, gf_r, bf_r;
  logic [7:0]  rb_r, gb_r, bb_r, ex_r;
  logic [7:0]  rbo, gbo, bbo;
  logic [31:0] rfo, gfo, bfo;

  assign en = out_ready || !v_r[2];
  assign in_ready = en;
  assign v_nxt = {v_r[1:0], in_valid};

  rpc_front u_front (
    .enc     (in_req_type == REQ_ENCODE),
    .red_f   (in_red_float_in),
    .green_f (in_green_float_in),
    .blue_f  (in_blue_float_in),
    .red_b   (in_red_byte_in),
    .green_b (in_green_byte_in),
    .blue_b  (in_blue_byte_in),
    .exp_b   (in_shared_exp_in),
    .ctl     (ctl_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 3'b000;
    end else if (en) begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl1_r <= ctl_nxt;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
      rf_r <= in_red_float_in;
      gf_r <= in_green_float_in;
      bf_r <= in_blue_float_in;
      rb_r <= in_red_byte_in;
      gb_r <= in_green_byte_in;
      bb_r <= in_blue_byte_in;
      ex_r <= in_shared_exp_in;
    end
  end

  rpc_lane u_red (
    .clk (clk), .en (en), .fl (rf_r), .byte_in (rb_r), .ex (ex_r), .ed (ctl1_r.ed),
    .byte_out (rbo), .float_out (rfo)
  );

  rpc_lane u_green (
    .clk (clk), .en (en), .fl (gf_r), .byte_in (gb_r), .ex (ex_r), .ed (ctl1_r.ed),
    .byte_out (gbo), .float_out (gfo)
  );

  rpc_lane u_blue (
    .clk (clk), .en (en), .fl (bf_r), .byte_in (bb_r), .ex (ex_r), .ed (ctl1_r.ed),
    .byte_out (bbo), .float_out (bfo)
  );

  // The merge stage picks the result form from the shared control word.
  always_comb begin
    out_red_float_out = 32'd0;
    out_green_float_out = 32'd0;
    out_blue_float_out = 32'd0;
    out_red_byte_out = 8'd0;
    out_green_byte_out = 8'd0;
    out_blue_byte_out = 8'd0;
    out_shared_exp_out = 8'd0;
    if (!ctl3_r.enc) begin
      if (!ctl3_r.zero) begin
        out_red_float_out = rfo;
        out_green_float_out = gfo;
        out_blue_float_out = bfo;
      end
    end else if (ctl3_r.sat) begin
      out_red_byte_out = 8'hFF;
      out_green_byte_out = 8'hFF;
      out_blue_byte_out = 8'hFF;
      out_shared_exp_out = 8'hFF;
    end else if (!ctl3_r.zero) begin
      out_red_byte_out = rbo;
      out_green_byte_out = gbo;
      out_blue_byte_out = bbo;
      out_shared_exp_out = ctl3_r.ed + EXP_OFFSET;
    end
  end

  assign out_valid = v_r[2];

endmodule
`default_nettype wire
